// ----- rtl/fpwb_pkg.sv -----
// Shared constants, payload types and controller/datapath interface types.
package fpwb_pkg;

    // Store geometry and access limits
    localparam int PAGE_SIZE        = 256;
    localparam int FLASH_PAGES      = 64;
    localparam int MAX_ACCESS_BYTES = 4;

    localparam int PAGE_AW     = $clog2(PAGE_SIZE);
    localparam int PAGE_W      = $clog2(FLASH_PAGES);
    localparam int STORE_BYTES = PAGE_SIZE * FLASH_PAGES;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 14;
    localparam int CNT_W    = 3;
    localparam int DATA_W   = 32;
    localparam int FIRST_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IW   = 1;

    // Byte address of one byte of an access may run one bit past the field
    localparam int BYTE_AW  = ADDR_W + 1;
    localparam int BPAGE_W  = BYTE_AW - PAGE_AW;
    localparam int LANE_W   = (MAX_ACCESS_BYTES > 1) ? $clog2(MAX_ACCESS_BYTES) : 1;
    localparam int LIMIT_W  = COUNT_W + 1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_PAGE_COUNT = 1'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
        logic [CNT_W-1:0]    byte_count;
        logic [DATA_W-1:0]   write_data;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              error;
    } t_out;

    // Controller -> datapath
    typedef struct packed {
        logic take_item;
        logic wb;
        logic load;
        logic byte_write;
        logic byte_capture;
        logic set_err;
        logic flush_end;
        logic emit;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_flush;
        logic is_rw;
        logic is_read;
        logic buf_valid;
        logic byte_end;
        logic byte_oor;
        logic byte_hit;
        logic sweep_last;
        logic slot_free;
    } t_stat;

endpackage

// ----- rtl/fpwb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fpwb_ctrl.sv -----
// Sequencing state machine: byte steps, write-back and load sweeps, result hand-off.
module fpwb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fpwb_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output fpwb_pkg::t_cmd o_cmd
);
    import fpwb_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_RDWAIT   = 3'd3;
    localparam logic [2:0] S_WB       = 3'd4;
    localparam logic [2:0] S_LOAD     = 3'd5;
    localparam logic [2:0] S_FLUSHEND = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_START;
                end
            end
            S_START: begin
                if (i_stat.is_flush) begin
                    n_state = i_stat.buf_valid ? S_WB : S_DONE;
                end else if (i_stat.is_rw) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHECK: begin
                if (i_stat.byte_end) begin
                    n_state = S_DONE;
                end else if (i_stat.byte_oor) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_DONE;
                end else if (!i_stat.byte_hit) begin
                    n_state = i_stat.buf_valid ? S_WB : S_LOAD;
                end else if (i_stat.is_read) begin
                    n_state = S_RDWAIT;
                end else begin
                    o_cmd.byte_write = 1'b1;
                end
            end
            S_RDWAIT: begin
                o_cmd.byte_capture = 1'b1;
                n_state            = S_CHECK;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = i_stat.is_flush ? S_FLUSHEND : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_CHECK;
                end
            end
            S_FLUSHEND: begin
                o_cmd.flush_end = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/fpwb_dp.sv -----
// Datapath: item and config registers, page buffer and flash store, result register.
module fpwb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpwb_pkg::t_in                 i_in_data,
    input  logic                          i_cfg_we,
    input  logic [fpwb_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [fpwb_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  fpwb_pkg::t_cmd                i_cmd,
    input  logic                          i_out_ready,
    output fpwb_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output fpwb_pkg::t_out                o_out_data
);
    import fpwb_pkg::*;

    // Configuration
    logic [FIRST_W-1:0] r_first;
    logic [COUNT_W-1:0] r_pcount;

    // Item and progress
    t_in               r_item;
    logic [CNT_W-1:0]  r_i;
    logic [DATA_W-1:0] r_rdata;
    logic              r_err;

    // Buffer state
    logic                   r_valid;
    logic [PAGE_W-1:0]      r_bp;
    logic                   r_diff;
    logic [FLASH_PAGES-1:0] r_written;
    logic                   r_mask;
    logic [PAGE_AW:0]       r_k;

    // Result slot
    logic r_out_valid;
    t_out r_out;

    logic [CNT_W-1:0]   w_cnt;
    logic [BYTE_AW-1:0] w_byte_addr;
    logic [BPAGE_W-1:0] w_page;
    logic [PAGE_AW-1:0] w_pos;
    logic [LIMIT_W-1:0] w_limit;
    logic               w_in_range;
    logic               w_k_last;
    logic [PAGE_AW-1:0] w_km1;
    logic [PAGE_W-1:0]  w_sweep_page;
    logic               w_sweep;
    logic [LANE_W-1:0]  w_lane;
    logic [7:0]         w_store_byte;

    logic               w_buf_we;
    logic [PAGE_AW-1:0] w_buf_waddr;
    logic [7:0]         w_buf_wdata;
    logic [PAGE_AW-1:0] w_buf_raddr;
    logic [7:0]         w_buf_rdata;
    logic [PAGE_AW+PAGE_W-1:0] w_st_waddr;
    logic [PAGE_AW+PAGE_W-1:0] w_st_raddr;
    logic [7:0]         w_st_rdata;

    assign w_cnt = (r_item.byte_count > CNT_W'(MAX_ACCESS_BYTES)) ?
                   CNT_W'(MAX_ACCESS_BYTES) : r_item.byte_count;
    assign w_byte_addr = {1'b0, r_item.address} + BYTE_AW'(r_i);
    assign w_page      = w_byte_addr[BYTE_AW-1:PAGE_AW];
    assign w_pos       = w_byte_addr[PAGE_AW-1:0];
    assign w_limit     = LIMIT_W'(r_first) + LIMIT_W'(r_pcount);
    assign w_in_range  = (32'(w_page) < FLASH_PAGES) &&
                         (w_page >= BPAGE_W'(r_first)) &&
                         (LIMIT_W'(w_page) < w_limit);
    assign w_lane      = r_i[LANE_W-1:0];

    assign w_sweep      = i_cmd.wb || i_cmd.load;
    assign w_k_last     = (r_k == (PAGE_AW+1)'(PAGE_SIZE));
    assign w_km1        = PAGE_AW'(r_k - 1'b1);
    assign w_sweep_page = i_cmd.wb ? r_bp : w_page[PAGE_W-1:0];
    // An erased page that was never written back reads as 0xFF
    assign w_store_byte = r_mask ? w_st_rdata : 8'hFF;

    // Page buffer ports
    assign w_buf_raddr = w_sweep ? r_k[PAGE_AW-1:0] : w_pos;
    assign w_buf_we    = (i_cmd.load && (r_k != '0)) || i_cmd.byte_write;
    assign w_buf_waddr = i_cmd.load ? w_km1 : w_pos;
    assign w_buf_wdata = i_cmd.load ? w_store_byte : r_item.write_data[8*w_lane +: 8];

    // Flash store ports
    assign w_st_raddr = {w_sweep_page, r_k[PAGE_AW-1:0]};
    assign w_st_waddr = {r_bp, w_km1};

    fpwb_ram #(.WIDTH(8), .DEPTH(PAGE_SIZE)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (w_buf_wdata),
        .i_raddr (w_buf_raddr),
        .o_rdata (w_buf_rdata)
    );

    fpwb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wb && (r_k != '0)),
        .i_waddr (w_st_waddr),
        .i_wdata (w_buf_rdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_pcount <= COUNT_W'(FLASH_PAGES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_PAGE: r_first  <= i_cfg_wdata[FIRST_W-1:0];
                CFG_PAGE_COUNT: r_pcount <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item payload and read data
    always_ff @(posedge i_clk) begin
        r_mask <= r_written[w_sweep_page];
        if (i_cmd.take_item) begin
            r_item  <= i_in_data;
            r_rdata <= '0;
        end else if (i_cmd.byte_capture) begin
            r_rdata[8*w_lane +: 8] <= w_buf_rdata;
        end
    end

    // Byte index and error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i   <= '0;
            r_err <= 1'b0;
        end else if (i_cmd.take_item) begin
            r_i   <= '0;
            r_err <= 1'b0;
        end else begin
            if (i_cmd.byte_write || i_cmd.byte_capture) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
        end
    end

    // Sweep counter, compare flag and buffer tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_diff    <= 1'b0;
            r_valid   <= 1'b0;
            r_bp      <= '0;
            r_written <= '0;
        end else begin
            if (w_sweep) begin
                r_k <= w_k_last ? '0 : r_k + 1'b1;
            end
            if (i_cmd.wb) begin
                if (r_k == '0) begin
                    r_diff <= 1'b0;
                end else if (w_buf_rdata != w_store_byte) begin
                    r_diff <= 1'b1;
                end
                if (w_k_last) begin
                    r_written[r_bp] <= 1'b1;
                end
            end
            if (i_cmd.load && w_k_last) begin
                r_bp    <= w_page[PAGE_W-1:0];
                r_valid <= 1'b1;
            end
            if (i_cmd.flush_end && r_diff) begin
                r_valid <= 1'b0;
                r_bp    <= '0;
            end
        end
    end

    // Result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.read_data <= r_rdata;
            r_out.error     <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.is_flush   = (r_item.action == ACT_FLUSH);
    assign o_stat.is_rw      = (r_item.action == ACT_READ) || (r_item.action == ACT_WRITE);
    assign o_stat.is_read    = (r_item.action == ACT_READ);
    assign o_stat.buf_valid  = r_valid;
    assign o_stat.byte_end   = (r_i == w_cnt);
    assign o_stat.byte_oor   = !w_in_range;
    assign o_stat.byte_hit   = r_valid && (w_page == BPAGE_W'(r_bp));
    assign o_stat.sweep_last = w_k_last;
    assign o_stat.slot_free  = !r_out_valid || i_out_ready;

endmodule

// ----- rtl/flash_page_write_back_buffer.sv -----
// Top level of the one-page write-back buffer in front of an on-chip flash store.
//
//   channel   direction  handshake                  word
//   in        input      i_in_valid / o_in_ready     t_in  (action, address, count, data)
//   out       output     o_out_valid / i_out_ready   t_out (read_data, error)
//   cfg       input      i_cfg_we, no wait           index + 7-bit value
//
// One item at a time. A hit byte is written to the buffer directly; a read hit passes a
// read-wait state. A miss adds a re-check and a load sweep, after a compare/write-back
// sweep when a page is held; a flush of a held page runs that sweep, then a flush-end step.
// Synchronous reset empties the buffer and flash reads erased (0xFF) through per-page
// written bits, with no clearing pass. A stalled result holds in the output register; the
// next item runs meanwhile, its result waits for it.
module flash_page_write_back_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fpwb_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fpwb_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [fpwb_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [fpwb_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import fpwb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: decides byte steps, sweeps and when the result leaves
    fpwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic: range check, hit test, compare/copy sweeps
    fpwb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Only one item in flight: a taken word drops ready on the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // Write-back only ever runs on a buffer that holds a page
    a_wb_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wb |-> w_stat.buf_valid)
        else $error("write-back sweep with empty buffer");

    // A finished load leaves the buffer holding a page
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load && w_stat.sweep_last |=> w_stat.buf_valid)
        else $error("load sweep did not mark buffer valid");

    // The two sweeps never overlap
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wb && w_cmd.load))
        else $error("write-back and load sweeps overlap");

endmodule
